// ===== hdl/gpioei_pkg.sv =====
// shared types and constants for the gpio port with edge interrupts
`timescale 1ns / 1ps

package gpioei_pkg;

    localparam int PIN_COUNT_DEF = 16;
    localparam int ALT_VEC_W     = 64;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [3:0] REG_MODE    = 4'd0;
    localparam logic [3:0] REG_OUTTYPE = 4'd1;
    localparam logic [3:0] REG_SPEED   = 4'd2;
    localparam logic [3:0] REG_PULL    = 4'd3;
    localparam logic [3:0] REG_INDATA  = 4'd4;
    localparam logic [3:0] REG_OUTDATA = 4'd5;
    localparam logic [3:0] REG_ALTLO   = 4'd6;
    localparam logic [3:0] REG_ALTHI   = 4'd7;
    localparam logic [3:0] REG_MASK    = 4'd8;
    localparam logic [3:0] REG_RISE    = 4'd9;
    localparam logic [3:0] REG_FALL    = 4'd10;
    localparam logic [3:0] REG_PENDING = 4'd11;

    localparam logic [1:0] MODE_GP_OUTPUT = 2'b01;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic [15:0] output_enable;
        logic        irq;
    } t_out_item;

endpackage

// ===== hdl/gpio_port_with_edge_interrupts_unit.sv =====
// top level of the gpio port with edge interrupts: input register, register bank, result register
`timescale 1ns / 1ps

// Each item (register write, register read or pin sample) is held in an input register until it
// commits, then updates the register bank and lands in the result register at the same edge.
// One item is taken every cycle while results are drained; the register bank takes each item
// in a single update, which sets that rate.
// The input side stalls only while an item waits in the input register behind an unread
// result. Read data reflects the registers before the item; pin drive, output enable and irq
// reflect them after it. PIN_COUNT may range from 8 to 16; register bits of absent pins read
// as zero and ignore writes.
module gpio_port_with_edge_interrupts_unit
    import gpioei_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;
    logic      commit;
    logic      in_take;
    t_out_item result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign commit     = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    gpioei_regs #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (commit) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("committed item did not reach the result register");

    a_read_only_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && (r_in_item.command != CMD_READ) |=> o_out_item.read_data == '0)
        else $error("nonzero read data for an item that is not a read");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !commit |=> r_in_valid && $stable(r_in_item))
        else $error("waiting item lost or overwritten");
`endif

endmodule

// ===== hdl/gpioei_regs.sv =====
// gpio register bank, edge detection and result formation
`timescale 1ns / 1ps

module gpioei_regs
    import gpioei_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_commit,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    localparam int PW = 2 * PIN_COUNT;
    localparam int AW = 4 * PIN_COUNT;

    logic [PW-1:0]        r_mode, n_mode;
    logic [PIN_COUNT-1:0] r_otype, n_otype;
    logic [PW-1:0]        r_speed, n_speed;
    logic [PW-1:0]        r_pull, n_pull;
    logic [PIN_COUNT-1:0] r_outdata, n_outdata;
    logic [AW-1:0]        r_alt, n_alt;
    logic [PIN_COUNT-1:0] r_mask, n_mask;
    logic [PIN_COUNT-1:0] r_rise, n_rise;
    logic [PIN_COUNT-1:0] r_fall, n_fall;
    logic [PIN_COUNT-1:0] r_pend, n_pend;
    logic [PIN_COUNT-1:0] r_indata, n_indata;

    logic [ALT_VEC_W-1:0] alt_rd;
    logic [ALT_VEC_W-1:0] alt_wr;
    logic [PIN_COUNT-1:0] levels;
    logic [PIN_COUNT-1:0] rise_hit;
    logic [PIN_COUNT-1:0] fall_hit;
    logic [PIN_COUNT-1:0] oe;
    logic [31:0]          rdata;

    assign levels   = i_item.pin_levels[PIN_COUNT-1:0];
    assign rise_hit = levels & ~r_indata & r_rise;
    assign fall_hit = ~levels & r_indata & r_fall;
    assign alt_rd   = ALT_VEC_W'(r_alt);

    always_comb begin
        n_mode    = r_mode;
        n_otype   = r_otype;
        n_speed   = r_speed;
        n_pull    = r_pull;
        n_outdata = r_outdata;
        n_alt     = r_alt;
        n_mask    = r_mask;
        n_rise    = r_rise;
        n_fall    = r_fall;
        n_pend    = r_pend;
        n_indata  = r_indata;
        alt_wr    = alt_rd;
        rdata     = '0;
        unique case (i_item.command)
            CMD_WRITE: begin
                unique case (i_item.reg_index)
                    REG_MODE:    n_mode    = i_item.write_data[PW-1:0];
                    REG_OUTTYPE: n_otype   = i_item.write_data[PIN_COUNT-1:0];
                    REG_SPEED:   n_speed   = i_item.write_data[PW-1:0];
                    REG_PULL:    n_pull    = i_item.write_data[PW-1:0];
                    REG_OUTDATA: n_outdata = i_item.write_data[PIN_COUNT-1:0];
                    REG_ALTLO: begin
                        alt_wr[31:0] = i_item.write_data;
                        n_alt        = alt_wr[AW-1:0];
                    end
                    REG_ALTHI: begin
                        alt_wr[63:32] = i_item.write_data;
                        n_alt         = alt_wr[AW-1:0];
                    end
                    REG_MASK:    n_mask    = i_item.write_data[PIN_COUNT-1:0];
                    REG_RISE:    n_rise    = i_item.write_data[PIN_COUNT-1:0];
                    REG_FALL:    n_fall    = i_item.write_data[PIN_COUNT-1:0];
                    REG_PENDING: n_pend    = r_pend & ~i_item.write_data[PIN_COUNT-1:0];
                    default: ;
                endcase
            end
            CMD_READ: begin
                unique case (i_item.reg_index)
                    REG_MODE:    rdata = 32'(r_mode);
                    REG_OUTTYPE: rdata = 32'(r_otype);
                    REG_SPEED:   rdata = 32'(r_speed);
                    REG_PULL:    rdata = 32'(r_pull);
                    REG_INDATA:  rdata = 32'(r_indata);
                    REG_OUTDATA: rdata = 32'(r_outdata);
                    REG_ALTLO:   rdata = alt_rd[31:0];
                    REG_ALTHI:   rdata = alt_rd[63:32];
                    REG_MASK:    rdata = 32'(r_mask);
                    REG_RISE:    rdata = 32'(r_rise);
                    REG_FALL:    rdata = 32'(r_fall);
                    REG_PENDING: rdata = 32'(r_pend);
                    default:     rdata = '0;
                endcase
            end
            CMD_SAMPLE: begin
                n_pend   = r_pend | rise_hit | fall_hit;
                n_indata = levels;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int p = 0; p < PIN_COUNT; p++) begin
            oe[p] = (n_mode[2*p +: 2] == MODE_GP_OUTPUT);
        end
    end

    assign o_result.read_data     = rdata;
    assign o_result.pin_drive     = 16'(n_outdata);
    assign o_result.output_enable = 16'(oe);
    assign o_result.irq           = |(n_pend & n_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= '0;
            r_otype   <= '0;
            r_speed   <= '0;
            r_pull    <= '0;
            r_outdata <= '0;
            r_alt     <= '0;
            r_mask    <= '0;
            r_rise    <= '0;
            r_fall    <= '0;
            r_pend    <= '0;
            r_indata  <= '0;
        end else if (i_commit) begin
            r_mode    <= n_mode;
            r_otype   <= n_otype;
            r_speed   <= n_speed;
            r_pull    <= n_pull;
            r_outdata <= n_outdata;
            r_alt     <= n_alt;
            r_mask    <= n_mask;
            r_rise    <= n_rise;
            r_fall    <= n_fall;
            r_pend    <= n_pend;
            r_indata  <= n_indata;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the gpio port with edge interrupts: directed and random items
`timescale 1ns / 1ps

module testbench;
    import gpioei_pkg::*;

    localparam int          PINS        = PIN_COUNT_DEF;
    localparam logic [1:0]  CMD_NONE    = 2'd3;
    localparam logic [31:0] PIN_MSK     = 32'((64'd1 << PINS) - 64'd1);
    localparam logic [31:0] PAIR_MSK    = 32'((64'd1 << (2 * PINS)) - 64'd1);
    localparam logic [31:0] ALT_HI_MSK  = 32'((64'd1 << (4 * (PINS - 8))) - 64'd1);
    localparam int          RANDOM_CNT  = 530;
    localparam int          HOLD_CYCLES = 60;
    localparam int          WATCHDOG    = 2000;

    typedef struct packed {
        logic     drain;
        t_in_item item;
    } t_stim;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    t_stim     stim_q[$];
    t_out_item port_results_q[$];
    int        total_items = 0;
    int        items_sent = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    // predicted register bank
    logic [31:0] mode_q, speed_q, pull_q, alt_lo_q, alt_hi_q;
    logic [31:0] otype_q, odata_q, imask_q, rise_q, fall_q, pend_q, idata_q;

    gpio_port_with_edge_interrupts_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
        error_count++;
    endtask

    function automatic logic [31:0] bank_read(input logic [3:0] idx);
        case (idx)
            REG_MODE:    return mode_q;
            REG_OUTTYPE: return otype_q;
            REG_SPEED:   return speed_q;
            REG_PULL:    return pull_q;
            REG_INDATA:  return idata_q;
            REG_OUTDATA: return odata_q;
            REG_ALTLO:   return alt_lo_q;
            REG_ALTHI:   return alt_hi_q;
            REG_MASK:    return imask_q;
            REG_RISE:    return rise_q;
            REG_FALL:    return fall_q;
            REG_PENDING: return pend_q;
            default:     return 32'd0;
        endcase
    endfunction

    task clear_bank();
        mode_q = '0; speed_q = '0; pull_q = '0; alt_lo_q = '0; alt_hi_q = '0;
        otype_q = '0; odata_q = '0; imask_q = '0; rise_q = '0; fall_q = '0;
        pend_q = '0; idata_q = '0;
    endtask

    // update the predicted bank with one item and queue the port result it causes
    task apply_gpio_item(input t_in_item it);
        t_out_item   res;
        logic [31:0] levels, v;
        levels = {16'd0, it.pin_levels} & PIN_MSK;
        v = it.write_data;
        res = '0;
        case (it.command)
            CMD_WRITE: begin
                case (it.reg_index)
                    REG_MODE:    mode_q = v & PAIR_MSK;
                    REG_OUTTYPE: otype_q = v & PIN_MSK;
                    REG_SPEED:   speed_q = v & PAIR_MSK;
                    REG_PULL:    pull_q = v & PAIR_MSK;
                    REG_OUTDATA: odata_q = v & PIN_MSK;
                    REG_ALTLO:   alt_lo_q = v;
                    REG_ALTHI:   alt_hi_q = v & ALT_HI_MSK;
                    REG_MASK:    imask_q = v & PIN_MSK;
                    REG_RISE:    rise_q = v & PIN_MSK;
                    REG_FALL:    fall_q = v & PIN_MSK;
                    REG_PENDING: pend_q = pend_q & ~v & PIN_MSK;
                    default: ;
                endcase
            end
            CMD_READ: res.read_data = bank_read(it.reg_index);
            CMD_SAMPLE: begin
                pend_q = (pend_q | (levels & ~idata_q & rise_q)
                          | (~levels & idata_q & fall_q)) & PIN_MSK;
                idata_q = levels;
            end
            default: ;
        endcase
        res.pin_drive = odata_q[15:0];
        for (int p = 0; p < PINS; p++) begin
            res.output_enable[p] = (mode_q[2 * p +: 2] == MODE_GP_OUTPUT);
        end
        res.irq = ((pend_q & imask_q) != 0);
        port_results_q.push_back(res);
    endtask

    task add_item(input logic [1:0] cmd, input logic [3:0] idx, input logic [31:0] wdata,
                  input logic [15:0] levels, input logic drain);
        t_stim s;
        s.drain = drain;
        s.item.command = cmd;
        s.item.reg_index = idx;
        s.item.write_data = wdata;
        s.item.pin_levels = levels;
        stim_q.push_back(s);
    endtask

    function automatic int send_idle_pct();
        if (items_sent < total_items / 3) return 28;
        if (items_sent < 2 * total_items / 3) return 58;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (items_sent < total_items / 3) return 58;
        if (items_sent < 2 * total_items / 3) return 28;
        return 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_item <= '0;
        end else begin
            if (in_valid && !in_stall) begin
                apply_gpio_item(in_item);
                items_sent <= items_sent + 1;
            end
            if (!in_valid || !in_stall) begin
                if (stim_q.size() > 0 && $urandom_range(99) >= send_idle_pct()
                    && !(stim_q[0].drain && port_results_q.size() != 0)) begin
                    in_valid <= 1'b1;
                    in_item <= stim_q.pop_front().item;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off early in the run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (!hold_done && items_sent >= 100) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct());
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (port_results_q.size() == 0) begin
                report("unexpected item read_data", out_item.read_data, 32'd0);
            end else begin
                want = port_results_q.pop_front();
                if (out_item.read_data !== want.read_data)
                    report("read_data", out_item.read_data, want.read_data);
                if (out_item.pin_drive !== want.pin_drive)
                    report("pin_drive", {16'd0, out_item.pin_drive}, {16'd0, want.pin_drive});
                if (out_item.output_enable !== want.output_enable)
                    report("output_enable", {16'd0, out_item.output_enable},
                           {16'd0, want.output_enable});
                if (out_item.irq !== want.irq)
                    report("irq", {31'd0, out_item.irq}, {31'd0, want.irq});
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int          r;
        logic [1:0]  cmd;
        logic [3:0]  idx;
        clear_bank();

        // directed items
        add_item(CMD_READ,   REG_PENDING, 32'd0,         16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_MODE,    32'h5555_5555, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_OUTDATA, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_OUTTYPE, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_SPEED,   32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_PULL,    32'hAAAA_5555, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_ALTLO,   32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_ALTHI,   32'h8765_4321, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_RISE,    32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_FALL,    32'hFFFF_FFFF, 16'h0000, 1'b0);
        // first sample after reset sees every high pin as rising
        add_item(CMD_SAMPLE, REG_MODE,    32'd0,         16'hFFFF, 1'b0);
        add_item(CMD_READ,   REG_PENDING, 32'd0,         16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_MASK,    32'h0000_8001, 16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_INDATA,  32'h0000_0000, 16'h0000, 1'b0);
        add_item(CMD_READ,   REG_INDATA,  32'd0,         16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_PENDING, 32'hFFFF_0001, 16'h0000, 1'b0);
        add_item(CMD_READ,   REG_PENDING, 32'd0,         16'h0000, 1'b0);
        add_item(CMD_WRITE,  4'd13,       32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_item(CMD_READ,   4'd15,       32'd0,         16'h0000, 1'b0);
        add_item(CMD_NONE,   REG_PENDING, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_item(CMD_SAMPLE, REG_MODE,    32'd0,         16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_PENDING, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_item(CMD_READ,   REG_ALTHI,   32'd0,         16'h0000, 1'b0);
        add_item(CMD_WRITE,  REG_MODE,    32'h0000_0000, 16'h0000, 1'b0);

        // random items
        for (int n = 0; n < RANDOM_CNT; n++) begin
            r = $urandom_range(99);
            if (r < 40) cmd = CMD_SAMPLE;
            else if (r < 65) cmd = CMD_WRITE;
            else if (r < 95) cmd = CMD_READ;
            else cmd = CMD_NONE;
            idx = ($urandom_range(99) < 92) ? 4'($urandom_range(11))
                                            : 4'($urandom_range(15, 12));
            add_item(cmd, idx, $urandom, 16'($urandom), n == RANDOM_CNT / 2);
        end
        total_items = stim_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() > 0 || in_valid || port_results_q.size() > 0)
            @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && port_results_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
